FILE: rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared sizes and action codes for the Fenwick range-add / point-query core.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

  localparam int SIZE   = 1024;
  localparam int NODE_W = 48;
  localparam int IDX_W  = 10;
  localparam int AMT_W  = 32;
  localparam int ACT_W  = 2;

  // node address, node number (1..SIZE), and compare width for positions
  localparam int ADDR_W = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int KW     = $clog2(SIZE + 1);
  localparam int PW     = (KW > IDX_W + 1) ? KW : IDX_W + 1;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/fenwick_range_add_point_query_core.sv
// ----------------------------------------------------------------------------
// fenwick_range_add_point_query_core
// Fenwick tree over a difference array: range add, point query, clear.
// ----------------------------------------------------------------------------
// Add: walks up to two node chains, reading (S_UP_RD) then writing back (S_UP_WR)
//   each node through the shared adder.
// Query: reads and adds one node per set bit of position + 1, then outputs the sum.
// Clear: one node written per cycle through the RAM write port.
// One item at a time; the single 48-bit adder and the RAM port set the rate.
// Reset: runs the same clearing pass with input stalled.
`default_nettype none

module fenwick_range_add_point_query_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [fra_pkg::ACT_W-1:0]           action,
  input  wire logic [fra_pkg::IDX_W-1:0]           first_index,
  input  wire logic [fra_pkg::IDX_W-1:0]           last_index,
  input  wire logic signed [fra_pkg::AMT_W-1:0]    amount,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [fra_pkg::NODE_W-1:0]        point_value
);

  localparam int NW = fra_pkg::NODE_W;
  localparam int AW = fra_pkg::ADDR_W;
  localparam int KW = fra_pkg::KW;
  localparam int PW = fra_pkg::PW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_UP_RD,
    S_UP_WR,
    S_Q_RD,
    S_Q_ACC,
    S_Q_OUT
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic [KW-1:0]   k;
  logic            second;
  logic [NW-1:0]   delta;
  logic [NW-1:0]   acc;
  logic [fra_pkg::IDX_W-1:0] last_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [NW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [NW-1:0]   ram_rdata;

  logic [KW-1:0]   k_minus;
  logic [KW-1:0]   low;
  logic [KW:0]     k_up;
  logic            up_done;
  logic [KW-1:0]   k_dn;
  logic [NW-1:0]   op;
  logic            cin;
  logic [NW-1:0]   sum;
  logic [PW-1:0]   first_ext;
  logic [PW-1:0]   q_pos;
  logic            first_ok;
  logic [PW-1:0]   last_plus;
  logic            second_ok;

  fra_ram #(
    .WIDTH (NW),
    .DEPTH (fra_pkg::SIZE)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // node index stepping
  always_comb begin
    k_minus = k - KW'(1);
    low     = k & (~k + KW'(1));
    k_up    = {1'b0, k} + {1'b0, low};
    up_done = k_up > (KW+1)'(fra_pkg::SIZE);
    k_dn    = k & k_minus;
  end

  // shared adder: node + delta, node - delta, or node + running sum
  always_comb begin
    if (state == S_Q_ACC) begin
      op  = acc;
      cin = 1'b0;
    end else begin
      op  = second ? ~delta : delta;
      cin = second;
    end
    sum = ram_rdata + op + NW'(cin);
  end

  always_comb begin
    first_ext = PW'(first_index);
    first_ok  = first_ext < PW'(fra_pkg::SIZE);
    q_pos     = first_ok ? first_ext : PW'(fra_pkg::SIZE - 1);
    last_plus = PW'(last_r) + PW'(1);
    second_ok = last_plus < PW'(fra_pkg::SIZE);
  end

  always_comb begin
    ram_raddr = k_minus[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = k_minus[AW-1:0];
    ram_wdata = sum;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_UP_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      second    <= 1'b0;
      k         <= KW'(1);
    end else begin
      if (out_valid && !out_stall && state != S_Q_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= last_index;
            delta  <= {{(NW - fra_pkg::AMT_W){amount[fra_pkg::AMT_W-1]}}, amount};
            acc    <= '0;
            case (action)
              fra_pkg::ACT_ADD: begin
                if (first_ok) begin
                  k      <= KW'(first_ext + PW'(1));
                  second <= 1'b0;
                  state  <= S_UP_RD;
                end else if (PW'(last_index) + PW'(1) < PW'(fra_pkg::SIZE)) begin
                  k      <= KW'(PW'(last_index) + PW'(2));
                  second <= 1'b1;
                  state  <= S_UP_RD;
                end
              end
              fra_pkg::ACT_QUERY: begin
                k     <= KW'(q_pos + PW'(1));
                state <= S_Q_RD;
              end
              fra_pkg::ACT_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(fra_pkg::SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_UP_RD: begin
          state <= S_UP_WR;
        end
        S_UP_WR: begin
          if (!up_done) begin
            k     <= k_up[KW-1:0];
            state <= S_UP_RD;
          end else if (!second && second_ok) begin
            k      <= KW'(last_plus + PW'(1));
            second <= 1'b1;
            state  <= S_UP_RD;
          end else begin
            second <= 1'b0;
            state  <= S_IDLE;
          end
        end
        S_Q_RD: begin
          state <= S_Q_ACC;
        end
        S_Q_ACC: begin
          acc <= sum;
          if (k_dn == '0) begin
            state <= S_Q_OUT;
          end else begin
            k     <= k_dn;
            state <= S_Q_RD;
          end
        end
        S_Q_OUT: begin
          if (!out_valid || !out_stall) begin
            point_value <= $signed(acc);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during clearing pass");

  a_node_write_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_WR) |-> (ram_waddr == $past(ram_raddr)))
    else $error("node written back to a different address than read");

  a_node_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_RD || state == S_Q_RD) |-> (k != '0))
    else $error("node index zero during walk");

  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_RD || state == S_Q_RD) |-> (k <= KW'(fra_pkg::SIZE)))
    else $error("node index beyond tree size");

endmodule

`default_nettype wire

FILE: rtl/fra_ram.sv
// ----------------------------------------------------------------------------
// fra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/fenwick_range_add_point_query_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_range_add_point_query_core_test
// Self-checking bench for the Fenwick range-add / point-query core. A plain
// per-position value array predicts every point query; range adds, clears and
// unused actions are driven with random gaps on the input side and random
// stalls on the result side, after a short directed run over the corners.
// ----------------------------------------------------------------------------

module fenwick_range_add_point_query_core_test;

  localparam int QUIET_LIMIT = 6000;
  localparam int TAIL_CYCLES = 100;
  localparam int ITEM_TARGET = 950;
  localparam logic [fra_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [fra_pkg::IDX_W-1:0] IDX_LAST =
    (fra_pkg::IDX_W)'(fra_pkg::SIZE - 1);

  class point_value_board;
    logic [fra_pkg::NODE_W-1:0] pos_val [fra_pkg::SIZE];
    logic [fra_pkg::NODE_W-1:0] want_q [$];
    int unsigned mismatches;

    function new();
      foreach (pos_val[i]) pos_val[i] = '0;
      mismatches = 0;
    endfunction

    function void note_beat(logic [fra_pkg::ACT_W-1:0] act, logic [fra_pkg::IDX_W-1:0] f,
                            logic [fra_pkg::IDX_W-1:0] l,
                            logic signed [fra_pkg::AMT_W-1:0] amt);
      logic [fra_pkg::NODE_W-1:0] delta;
      int p;
      int q;
      delta = {{(fra_pkg::NODE_W-fra_pkg::AMT_W){amt[fra_pkg::AMT_W-1]}}, amt};
      case (act)
        fra_pkg::ACT_ADD: begin
          if (int'(f) < fra_pkg::SIZE)
            for (p = int'(f); p < fra_pkg::SIZE; p++) pos_val[p] = pos_val[p] + delta;
          if (int'(l) + 1 < fra_pkg::SIZE)
            for (p = int'(l) + 1; p < fra_pkg::SIZE; p++) pos_val[p] = pos_val[p] - delta;
        end
        fra_pkg::ACT_QUERY: begin
          q = (int'(f) >= fra_pkg::SIZE) ? fra_pkg::SIZE - 1 : int'(f);
          want_q = {want_q, pos_val[q]};
        end
        fra_pkg::ACT_CLEAR: begin
          foreach (pos_val[i]) pos_val[i] = '0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_beat(logic [fra_pkg::NODE_W-1:0] got);
      logic [fra_pkg::NODE_W-1:0] want;
      if (want_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected point_value %0d", $realtime, $signed(got));
        mismatches++;
      end else begin
        want = want_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("%0t: point_value expected %0d got %0d", $realtime,
                     $signed(want), $signed(got));
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [fra_pkg::ACT_W-1:0]         action;
  logic [fra_pkg::IDX_W-1:0]         first_index;
  logic [fra_pkg::IDX_W-1:0]         last_index;
  logic signed [fra_pkg::AMT_W-1:0]  amount;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [fra_pkg::NODE_W-1:0] point_value;

  point_value_board sb = new();
  int src_idle_pct;
  int sink_stall_pct;
  int stall_left;
  int quiet_cycles = 0;

  fenwick_range_add_point_query_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .first_index (first_index),
    .last_index  (last_index),
    .amount      (amount),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_value (point_value)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap(int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [fra_pkg::IDX_W-1:0] to_idx(int v);
    return (fra_pkg::IDX_W)'(v);
  endfunction

  function automatic logic [fra_pkg::IDX_W-1:0] pick_index();
    case ($urandom_range(7))
      0: return '0;
      1: return IDX_LAST;
      default: return to_idx($urandom_range(fra_pkg::SIZE - 1));
    endcase
  endfunction

  function automatic logic signed [fra_pkg::AMT_W-1:0] pick_amount();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $signed($urandom_range(200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [fra_pkg::ACT_W-1:0] act, logic [fra_pkg::IDX_W-1:0] f,
                           logic [fra_pkg::IDX_W-1:0] l,
                           logic signed [fra_pkg::AMT_W-1:0] amt);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    first_index <= f;
    last_index  <= l;
    amount      <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result-side stall: short bursts, a few long ones
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(2);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_beat(action, first_index, last_index, amount);
    if (!rst && out_valid && !out_stall)
      sb.check_beat(point_value);
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [fra_pkg::ACT_W-1:0] act;
    logic [fra_pkg::IDX_W-1:0] f;
    logic [fra_pkg::IDX_W-1:0] l;
    int n;
    int r;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= fra_pkg::ACT_ADD;
    first_index <= '0;
    last_index  <= '0;
    amount      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_item(fra_pkg::ACT_QUERY, '0, '0, 0);
    send_item(fra_pkg::ACT_ADD, '0, IDX_LAST, 32'sh7FFF_FFFF);
    send_item(fra_pkg::ACT_QUERY, '0, '0, 0);
    send_item(fra_pkg::ACT_QUERY, IDX_LAST, '0, 0);
    send_item(fra_pkg::ACT_ADD, to_idx(512), IDX_LAST, 32'sh8000_0000);
    send_item(fra_pkg::ACT_QUERY, to_idx(511), '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(512), '0, 0);
    send_item(fra_pkg::ACT_ADD, to_idx(700), to_idx(300), 1000);
    send_item(fra_pkg::ACT_QUERY, to_idx(300), '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(301), '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(699), '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(700), '0, 0);
    send_item(fra_pkg::ACT_ADD, IDX_LAST, '0, -5);
    send_item(fra_pkg::ACT_QUERY, '0, '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(1), '0, 0);
    send_item(fra_pkg::ACT_QUERY, IDX_LAST, '0, 0);
    send_item(ACT_UNUSED, IDX_LAST, IDX_LAST, 32'sh7FFF_FFFF);
    send_item(fra_pkg::ACT_QUERY, IDX_LAST, IDX_LAST, -1);
    send_item(fra_pkg::ACT_CLEAR, IDX_LAST, IDX_LAST, -1);
    send_item(fra_pkg::ACT_QUERY, IDX_LAST, '0, 0);
    send_item(fra_pkg::ACT_ADD, to_idx(5), to_idx(5), -1);
    send_item(fra_pkg::ACT_QUERY, to_idx(5), '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(4), '0, 0);
    send_item(fra_pkg::ACT_QUERY, to_idx(6), '0, 0);

    // random traffic, idling changes every 150 items
    n = 0;
    while (n < ITEM_TARGET) begin
      case ((n / 150) % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 30; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 40; end
        default: begin src_idle_pct = 40; sink_stall_pct = 50; end
      endcase
      r = $urandom_range(99);
      f = pick_index();
      l = pick_index();
      if (r < 48) begin
        act = fra_pkg::ACT_ADD;
        if ($urandom_range(9) != 0 && f > l) begin
          l = to_idx(int'(f) + int'($urandom_range(16)));
          if (l < f) l = IDX_LAST;
        end
      end else if (r < 95) begin
        act = fra_pkg::ACT_QUERY;
      end else if (r < 97) begin
        act = fra_pkg::ACT_CLEAR;
      end else begin
        act = ACT_UNUSED;
      end
      send_item(act, f, l, pick_amount());
      if (act != ACT_UNUSED) n++;
    end
    in_valid <= 1'b0;

    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
